[rtl/sorted_table_binary_search_unit_defines.svh]
// assertion macros shared by the sorted table binary search unit
// no dependencies; included by modules that carry concurrent assertions
`ifndef SORTED_TABLE_BINARY_SEARCH_UNIT_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication, masked while reset is low
`define SBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is low
`define SBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sbs_pkg.sv]
// shared types and constants for the sorted table binary search unit
// no dependencies
`default_nettype none

package sbs_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = IDX_W + 1;
    localparam int CFG_W   = 5;
    localparam int POS_W   = 4;
    localparam int INDEX_W = 4;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-1:0] ADDR_TABLE_SIZE = 3'd0;
    localparam logic [CFG_W-1:0]   TABLE_SIZE_RST  = 5'd16;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef struct packed {
        logic                     action;
        logic [INDEX_W-1:0]       index;
        logic signed [DATA_W-1:0] value;
    } t_sbs_in;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_sbs_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_COMPARE,
        S_FINISH
    } t_sbs_state;

    typedef struct packed {
        logic wr;
        logic load;
        logic probe;
        logic step;
        logic finish;
    } t_sbs_cmd;

    typedef struct packed {
        logic range_ok;
        logic hit;
        logic out_busy;
    } t_sbs_status;

endpackage

`default_nettype wire

[rtl/sbs_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module sbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[rtl/sbs_ctrl.sv]
// search sequencer: state machine that drives the datapath commands
// depends on sbs_pkg and the assertion macro header
`default_nettype none
`include "sorted_table_binary_search_unit_defines.svh"

module sbs_ctrl
    import sbs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_action,
    output logic             o_in_ready,
    input  wire t_sbs_status i_status,
    output t_sbs_cmd         o_cmd
);

    t_sbs_state r_state;
    t_sbs_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && (i_action == ACT_SEARCH)) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                n_state = i_status.range_ok ? S_COMPARE : S_FINISH;
            end
            S_COMPARE: begin
                n_state = i_status.hit ? S_FINISH : S_PROBE;
            end
            S_FINISH: begin
                if (!i_status.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.wr    = i_in_valid && (i_action == ACT_WRITE);
                o_cmd.load  = i_in_valid && (i_action == ACT_SEARCH);
            end
            S_PROBE: begin
                o_cmd.probe = i_status.range_ok;
            end
            S_COMPARE: begin
                o_cmd.step = 1'b1;
            end
            S_FINISH: begin
                o_cmd.finish = !i_status.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    `SBS_ASSERT_NXT(a_probe_to_compare, i_clk, i_rst_n,
        (r_state == S_PROBE) && i_status.range_ok, r_state == S_COMPARE,
        "probe with bounds open did not move to compare")
    `SBS_ASSERT_NXT(a_miss_reprobes, i_clk, i_rst_n,
        (r_state == S_COMPARE) && !i_status.hit, r_state == S_PROBE,
        "compare miss did not return to probe")
    `SBS_ASSERT_IMP(a_finish_when_free, i_clk, i_rst_n,
        o_cmd.finish, !i_status.out_busy && (r_state == S_FINISH),
        "result loaded while output register busy")

endmodule

`default_nettype wire

[rtl/sbs_datapath.sv]
// search datapath: entry ram, bounds, compare, result and output register
// depends on sbs_pkg, sbs_ram and the assertion macro header
`default_nettype none
`include "sorted_table_binary_search_unit_defines.svh"

module sbs_datapath
    import sbs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_sbs_in          i_in_data,
    input  wire logic [CFG_W-1:0] i_table_size,
    input  wire t_sbs_cmd         i_cmd,
    output t_sbs_status           o_status,
    output logic                  o_out_valid,
    output t_sbs_out              o_out_data,
    input  wire logic             i_out_ready
);

    logic [CNT_W-1:0]         r_lo;
    logic [CNT_W-1:0]         n_lo;
    logic [CNT_W-1:0]         r_hend;
    logic [CNT_W-1:0]         n_hend;
    logic signed [DATA_W-1:0] r_key;
    logic                     r_found;
    logic                     n_found;
    logic [POS_W-1:0]         r_pos;
    logic [POS_W-1:0]         n_pos;
    logic                     r_out_valid;
    logic                     n_out_valid;
    t_sbs_out                 r_out;

    logic [CNT_W-1:0]         w_n;
    logic [CNT_W:0]           w_sum;
    logic [IDX_W-1:0]         w_mid;
    logic                     w_wr_ok;
    logic [DATA_W-1:0]        w_rd_data;
    logic signed [DATA_W-1:0] w_entry;

    // clamp the configured size to the table depth
    assign w_n = (32'(i_table_size) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(i_table_size);

    // midpoint of lo and hi = hend - 1, rounded down
    assign w_sum = (CNT_W+1)'(r_lo) + (CNT_W+1)'(r_hend) - (CNT_W+1)'(1);
    assign w_mid = w_sum[IDX_W:1];

    assign w_wr_ok = i_cmd.wr && (32'(i_in_data.index) < DEPTH);

    sbs_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_ok),
        .i_wr_addr (IDX_W'(i_in_data.index)),
        .i_wr_data (i_in_data.value),
        .i_rd_en   (i_cmd.probe),
        .i_rd_addr (w_mid),
        .o_rd_data (w_rd_data)
    );

    assign w_entry = $signed(w_rd_data);

    always_comb begin
        n_lo    = r_lo;
        n_hend  = r_hend;
        n_found = r_found;
        n_pos   = r_pos;
        if (i_cmd.load) begin
            n_lo    = '0;
            n_hend  = w_n;
            n_found = 1'b0;
            n_pos   = '0;
        end else if (i_cmd.step) begin
            if (w_entry == r_key) begin
                n_found = 1'b1;
                n_pos   = POS_W'(w_mid);
            end else if (w_entry > r_key) begin
                n_hend = CNT_W'(w_mid);
            end else begin
                n_lo = CNT_W'(w_mid) + CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo        <= '0;
            r_hend      <= '0;
            r_found     <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_lo        <= n_lo;
            r_hend      <= n_hend;
            r_found     <= n_found;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_in_data.value;
        end
        if (i_cmd.finish) begin
            r_out.found    <= r_found;
            r_out.position <= r_pos;
        end
    end

    assign o_status.range_ok = r_lo < r_hend;
    assign o_status.hit      = w_entry == r_key;
    assign o_status.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SBS_ASSERT_IMP(a_bounds_ordered, i_clk, i_rst_n,
        1'b1, r_lo <= r_hend,
        "low bound passed the high bound")
    `SBS_ASSERT_IMP(a_hend_in_table, i_clk, i_rst_n,
        1'b1, 32'(r_hend) <= DEPTH,
        "high bound beyond table depth")
    `SBS_ASSERT_NXT(a_finish_shows_result, i_clk, i_rst_n,
        i_cmd.finish, r_out_valid && (r_out.found || (r_out.position == '0)),
        "finished search not presented, or miss with nonzero position")

endmodule

`default_nettype wire

[rtl/sorted_table_binary_search_unit.sv]
// top level of the sorted table binary search unit: apb register, sequencer
// and datapath; depends on sbs_pkg, sbs_ctrl, sbs_datapath (and sbs_ram)
`default_nettype none

// Holds a table of DEPTH signed entries (16 x 16 bits) in a small ram and
// searches it for a key. An input transaction with action = write stores
// value at index (an index at or above DEPTH is dropped); it gives no
// result. An input transaction with action = search runs a classic binary
// search over entries 0 .. table_size-1 (table_size above DEPTH is clamped
// to DEPTH) and gives exactly one result transaction: found, and position
// of the first probed match, or found = 0 and position = 0. A search is
// accepted in IDLE; each probe then puts the ram read address out (PROBE)
// and compares the registered read data (COMPARE), and FINISH loads the
// output register, waiting while that register still holds a result not
// yet taken. A miss ends on a PROBE that finds the bounds crossed (an empty
// table goes straight there). A search makes at most floor(log2(n)) + 1
// probes, five for n = 16; each probe needs both PROBE and COMPARE since the
// ram's read port is registered. Searches run one at a time; a new
// transaction is accepted while a finished result still waits in the output
// register. table_size is at byte address 0 of the apb port (reset 16) and
// may only be written while no search is in flight. Entries never written
// hold unknown data; searching over them gives an unspecified result.

module sorted_table_binary_search_unit
    import sbs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_sbs_in            i_in_data,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_sbs_out                o_out_data,
    // apb configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    logic [CFG_W-1:0] r_table_size;
    logic [CFG_W-1:0] n_table_size;
    logic             w_cfg_wr;
    t_sbs_cmd         w_cmd;
    t_sbs_status      w_status;

    // apb write completes in the access phase; no wait states
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr == ADDR_TABLE_SIZE);

    always_comb begin
        n_table_size = r_table_size;
        if (w_cfg_wr) begin
            n_table_size = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TABLE_SIZE_RST;
        end else begin
            r_table_size <= n_table_size;
        end
    end

    // register read back; unmapped addresses read as zero
    always_comb begin
        prdata = '0;
        if (paddr == ADDR_TABLE_SIZE) begin
            prdata = PDATA_W'(r_table_size);
        end
    end

    // sequencer: one search at a time, writes pass straight to the ram
    sbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_data.action),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // bounds, compare and output register
    sbs_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_data    (i_in_data),
        .i_table_size (r_table_size),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_ready  (i_out_ready)
    );

endmodule

`default_nettype wire

[test/sbs_search_checker.sv]
// result checker for the sorted table binary search unit: follows the table
// writes, the apb register and the result channel; depends on sbs_pkg
module sbs_search_checker
    import sbs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire t_sbs_in            i_in_data,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire t_sbs_out           i_out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    input  wire logic [PDATA_W-1:0] prdata,
    input  wire logic               pready,
    output int unsigned             o_pending,
    output int unsigned             o_fail_count
);

    logic signed [DATA_W-1:0] table_copy [DEPTH];
    logic [CFG_W-1:0]         size_reg = TABLE_SIZE_RST;
    t_sbs_out                 owed_results [$];
    int unsigned              fails = 0;

    // midpoint rounded down, stop at the first equal probe
    function automatic t_sbs_out search_table(input logic signed [DATA_W-1:0] key);
        int       lo;
        int       hi;
        int       mid;
        int       span;
        t_sbs_out res;
        res  = '0;
        span = (size_reg > DEPTH) ? DEPTH : int'(size_reg);
        lo   = 0;
        hi   = span - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (table_copy[mid] == key) begin
                res.found    = 1'b1;
                res.position = mid[POS_W-1:0];
                return res;
            end
            if (table_copy[mid] > key)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_sbs_out want;
        if (!i_rst_n) begin
            size_reg = TABLE_SIZE_RST;
            owed_results.delete();
        end else begin
            if (psel && penable && pready && paddr == ADDR_TABLE_SIZE) begin
                if (pwrite) begin
                    size_reg = pwdata[CFG_W-1:0];
                end else if (prdata[CFG_W-1:0] !== size_reg) begin
                    $error("table_size mismatch: expected %0d, actual %0d",
                           size_reg, prdata[CFG_W-1:0]);
                    fails++;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (owed_results.size() == 0) begin
                    $error("result transaction with no search outstanding");
                    fails++;
                end else begin
                    want = owed_results.pop_front();
                    if (i_out_data.found !== want.found) begin
                        $error("found mismatch: expected %0d, actual %0d",
                               want.found, i_out_data.found);
                        fails++;
                    end
                    if (i_out_data.position !== want.position) begin
                        $error("position mismatch: expected %0d, actual %0d",
                               want.position, i_out_data.position);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.action == ACT_SEARCH)
                    owed_results.push_back(search_table(i_in_data.value));
                else
                    table_copy[i_in_data.index] = i_in_data.value;
            end
        end
        o_pending    <= owed_results.size();
        o_fail_count <= fails;
    end

endmodule

[test/testbench.sv]
// top of the binary search unit testbench: clock, reset, stimulus and verdict
// depends on sbs_pkg, sorted_table_binary_search_unit and sbs_search_checker
module testbench;
    import sbs_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int ITEM_TARGET   = 750;
    // slack left after the last result has been taken
    localparam int SETTLE_CYCLES = 16;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    t_sbs_in            i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_sbs_out           o_out_data;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int unsigned results_owed;
    int unsigned mismatch_count;

    // stimulus-side copy of the table, only used to aim keys at stored entries
    logic signed [DATA_W-1:0] shadow [DEPTH];
    int unsigned              table_size_now = 32'(TABLE_SIZE_RST);
    int unsigned              items_sent     = 0;
    // per-stretch limits on the random gaps of each side
    int unsigned              in_gap_max     = 2;
    int unsigned              out_wait_max   = 2;
    int unsigned              out_hold       = 0;
    logic                     hold_drawn     = 1'b0;

    sorted_table_binary_search_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    sbs_search_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_pending    (results_owed),
        .o_fail_count (mismatch_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin : watchdog
        #(CLK_PERIOD * 400000);
        $display("testbench: FAIL");
        $finish;
    end

    // result side: per result, wait a random 0..out_wait_max before taking it;
    // with a limit of 0 ready simply stays high
    always @(posedge i_clk) begin : result_sink
        int unsigned wait_cycles;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_hold    <= 0;
            hold_drawn  <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            // transaction taken, throttle the next one unless unthrottled
            i_out_ready <= (out_wait_max == 0);
            hold_drawn  <= 1'b0;
        end else if (out_hold != 0) begin
            out_hold <= out_hold - 1;
            if (out_hold == 1)
                i_out_ready <= 1'b1;
        end else if (o_out_valid && !i_out_ready && !hold_drawn) begin
            wait_cycles = $urandom_range(0, out_wait_max);
            hold_drawn  <= 1'b1;
            if (wait_cycles == 0)
                i_out_ready <= 1'b1;
            else
                out_hold <= wait_cycles;
        end else if (out_wait_max == 0) begin
            i_out_ready <= 1'b1;
        end
    end

    // one input transaction, after a random gap; valid is only dropped when a
    // gap follows, so it never toggles within one time step
    task automatic send_item(input t_sbs_in item);
        int unsigned gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic write_entry(input logic [INDEX_W-1:0] idx,
                               input logic signed [DATA_W-1:0] val);
        t_sbs_in item;
        item.action = ACT_WRITE;
        item.index  = idx;
        item.value  = val;
        send_item(item);
        shadow[idx] = val;
    endtask

    // index is don't-care for a search, so it is randomized
    task automatic search_key(input logic signed [DATA_W-1:0] key);
        t_sbs_in item;
        item.action = ACT_SEARCH;
        item.index  = INDEX_W'($urandom_range(0, DEPTH - 1));
        item.value  = key;
        send_item(item);
    endtask

    // stop sending and wait until every search has answered and the block
    // has had time to settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_owed != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // setup cycle, then access cycle, then idle so that psel never
    // drops and rises in the same step
    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // ascending table from a random start with random steps up to step_max;
    // the start is chosen so the last entry cannot overflow
    task automatic load_sorted_table(input int unsigned step_max);
        logic signed [DATA_W-1:0] fresh [DEPTH];
        int                       v;
        int unsigned              first;
        v = -32768 + int'($urandom_range(0, 65535 - (DEPTH - 1) * step_max));
        for (int i = 0; i < DEPTH; i++) begin
            fresh[i] = DATA_W'(v);
            v += int'($urandom_range(0, step_max));
        end
        // write order rotated so entries land in varying order
        first = $urandom_range(0, DEPTH - 1);
        for (int k = 0; k < DEPTH; k++)
            write_entry(INDEX_W'((first + k) % DEPTH), fresh[(first + k) % DEPTH]);
    endtask

    // half the keys hit an entry of the searched range, a quarter are one off an
    // entry, a quarter are anywhere in the 16-bit range
    function automatic logic signed [DATA_W-1:0] pick_key(input int unsigned span);
        int unsigned k;
        int unsigned sel;
        k   = (span == 0) ? $urandom_range(0, DEPTH - 1) : $urandom_range(0, span - 1);
        sel = $urandom_range(0, 7);
        if (sel < 4)
            return shadow[k];
        else if (sel == 4)
            return DATA_W'(shadow[k] + 1);
        else if (sel == 5)
            return DATA_W'(shadow[k] - 1);
        return DATA_W'($urandom);
    endfunction

    initial begin : stimulus
        int unsigned stretch;
        int unsigned span;
        int unsigned new_size;
        int unsigned batch;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: table with both extremes at the ends, every entry written
        // before any search so nothing unwritten is ever probed
        for (int i = DEPTH - 1; i >= 0; i--)
            write_entry(INDEX_W'(i),
                        DATA_W'((i == 0) ? -32768 : (i == DEPTH - 1) ? 32767 : (i - 7) * 4000));
        search_key(DATA_W'(-32768));  // hit at the lowest entry
        search_key(DATA_W'(32767));   // hit at the highest entry
        search_key(DATA_W'(0));       // hit on the first probe
        search_key(DATA_W'(4000));    // hit after walking right
        search_key(DATA_W'(1));       // miss between two entries
        search_key(DATA_W'(-32767));  // miss just above the minimum

        // random stretches, each under its own table_size; the first few
        // cover empty, tiny and oversized tables
        stretch = 0;
        while (items_sent < ITEM_TARGET) begin
            // register changes only while the block is idle
            drain_results();
            case (stretch)
                0:       new_size = 0;
                1:       new_size = 1;
                2:       new_size = 2;
                3:       new_size = 31;
                4:       new_size = 17;
                5:       new_size = DEPTH;
                6:       new_size = 3;
                default: new_size = ($urandom_range(0, 3) == 0) ?
                                    $urandom_range(0, 31) : $urandom_range(9, DEPTH);
            endcase
            apb_access(1'b1, ADDR_TABLE_SIZE, PDATA_W'(new_size));
            apb_access(1'b0, ADDR_TABLE_SIZE, '0);
            table_size_now = new_size;

            // some stretches run with no gaps at all on one or both sides
            in_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 4;
            out_wait_max = ($urandom_range(0, 3) == 0) ? 0 : 4;

            if (stretch == 0 || $urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 3))
                    0:       load_sorted_table(1);    // long runs of duplicates
                    1:       load_sorted_table(20);
                    2:       load_sorted_table(600);
                    default: load_sorted_table(4369); // spans the whole range
                endcase
            end
            // now and then scribble over a few entries, leaving it unsorted
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 3))
                    write_entry(INDEX_W'($urandom_range(0, DEPTH - 1)), DATA_W'($urandom));

            span  = (table_size_now > DEPTH) ? DEPTH : table_size_now;
            batch = $urandom_range(15, 35);
            repeat (batch) begin
                // stray writes break up the search runs
                if ($urandom_range(0, 19) == 0)
                    write_entry(INDEX_W'($urandom_range(0, DEPTH - 1)), DATA_W'($urandom));
                search_key(pick_key(span));
            end
            stretch++;
        end

        drain_results();
        if (mismatch_count == 0 && results_owed == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/sbs_pkg.sv
rtl/sbs_ram.sv
rtl/sbs_ctrl.sv
rtl/sbs_datapath.sv
rtl/sorted_table_binary_search_unit.sv
test/sbs_search_checker.sv
test/testbench.sv
